// ----- rtl/lse_pkg.sv -----
package lse_pkg;

  localparam int TICK_COUNT_BITS = 12;
  localparam int PIXEL_BITS      = 24;
  localparam int COLOR_BITS      = 8;
  localparam int BIT_POS_BITS    = 5;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int QUEUE_DEPTH     = 2;
  localparam int QUEUE_PTR_BITS  = 1;
  localparam int QUEUE_CNT_BITS  = 2;

  localparam logic [BIT_POS_BITS-1:0] PIXEL_TOP_BIT = BIT_POS_BITS'(PIXEL_BITS - 1);

  localparam logic [TICK_COUNT_BITS-1:0] ZERO_HIGH_RESET = TICK_COUNT_BITS'(25);
  localparam logic [TICK_COUNT_BITS-1:0] ZERO_LOW_RESET  = TICK_COUNT_BITS'(125);
  localparam logic [TICK_COUNT_BITS-1:0] ONE_HIGH_RESET  = TICK_COUNT_BITS'(75);
  localparam logic [TICK_COUNT_BITS-1:0] ONE_LOW_RESET   = TICK_COUNT_BITS'(75);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ZERO_HIGH = 3'd0,
    REG_ZERO_LOW  = 3'd1,
    REG_ONE_HIGH  = 3'd2,
    REG_ONE_LOW   = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                  is_load;
    logic [PIXEL_BITS-1:0] pixel;
  } step_t;

endpackage

// ----- rtl/lse_ifs.sv -----
interface lse_item_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [lse_pkg::COLOR_BITS-1:0] red;
  logic [lse_pkg::COLOR_BITS-1:0] green;
  logic [lse_pkg::COLOR_BITS-1:0] blue;

  modport source (output valid, kind, red, green, blue, input ready);
  modport sink   (input valid, kind, red, green, blue, output ready);
endinterface

interface lse_result_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic refused;

  modport source (output valid, line_level, busy_res, refused, input ready);
  modport sink   (input valid, line_level, busy_res, refused, output ready);
endinterface

// ----- rtl/rgb_led_serial_line_encoder.sv -----
// Single-wire RGB LED line encoder. Each item beat is either one timing tick
// (kind 0) or a pixel load (kind 1, sent green, red, blue, MSB first); every
// beat yields exactly one result beat with the line level, busy flag and a
// refused flag for a load that arrived while a pixel was still going out.
// One beat is taken per clock while the queue has room; beats are decoded
// into a two-entry queue and run by the bit sequencer, whose state and
// result registers update as a beat is popped: one beat per cycle while the
// receiver takes results. The user must write tick counts (cfg_we/cfg_index/
// cfg_data) only while no beat is in flight; the block does not enforce this.
// Counts take effect at the next phase start; a count of zero acts as one tick.
module rgb_led_serial_line_encoder (
  input  logic                                clk,
  input  logic                                rst,
  lse_item_if.sink                            items,
  lse_result_if.source                        results,
  input  logic                                cfg_we,
  input  logic [lse_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [lse_pkg::TICK_COUNT_BITS-1:0] cfg_data
);

  logic           q_full;
  logic           q_not_empty;
  logic           push;
  logic           pop;
  lse_pkg::step_t push_data;
  lse_pkg::step_t pop_data;

  lse_front u_front (
    .items     (items),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  lse_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  lse_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (pop_data),
    .pop         (pop),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .results     (results)
  );

endmodule

// ----- rtl/lse_front.sv -----
module lse_front (
  lse_item_if.sink         items,
  input  logic             q_full,
  output logic             push,
  output lse_pkg::step_t   push_data
);

  assign items.ready = !q_full;
  assign push        = items.valid && !q_full;

  // green, red, blue packed MSB first
  always_comb begin
    push_data.is_load = items.kind;
    push_data.pixel   = {items.green, items.red, items.blue};
  end

endmodule

// ----- rtl/lse_queue.sv -----
module lse_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lse_pkg::step_t push_data,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output lse_pkg::step_t pop_data
);

  lse_pkg::step_t                     slots [lse_pkg::QUEUE_DEPTH];
  logic [lse_pkg::QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [lse_pkg::QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [lse_pkg::QUEUE_CNT_BITS-1:0] count;

  assign full      = (count == lse_pkg::QUEUE_CNT_BITS'(lse_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/lse_back.sv -----
module lse_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_not_empty,
  input  lse_pkg::step_t                      q_data,
  output logic                                pop,
  input  logic                                cfg_we,
  input  logic [lse_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [lse_pkg::TICK_COUNT_BITS-1:0] cfg_data,
  lse_result_if.source                        results
);

  logic [lse_pkg::TICK_COUNT_BITS-1:0] zero_high_ticks;
  logic [lse_pkg::TICK_COUNT_BITS-1:0] zero_low_ticks;
  logic [lse_pkg::TICK_COUNT_BITS-1:0] one_high_ticks;
  logic [lse_pkg::TICK_COUNT_BITS-1:0] one_low_ticks;

  logic [lse_pkg::PIXEL_BITS-1:0]      pixel_shift, pixel_shift_next;
  logic [lse_pkg::BIT_POS_BITS-1:0]    bit_position, bit_position_next;
  logic                                in_low_phase, in_low_phase_next;
  logic [lse_pkg::TICK_COUNT_BITS-1:0] ticks_left, ticks_left_next;
  logic                                sending, sending_next;
  logic                                refused_next;
  logic [lse_pkg::TICK_COUNT_BITS-1:0] ticks_dec;

  logic                                out_valid;
  logic                                out_line;
  logic                                out_busy;
  logic                                out_refused;

  function automatic logic [lse_pkg::TICK_COUNT_BITS-1:0] phase_len(
    input logic                                bit_val,
    input logic                                low,
    input logic [lse_pkg::TICK_COUNT_BITS-1:0] zh,
    input logic [lse_pkg::TICK_COUNT_BITS-1:0] zl,
    input logic [lse_pkg::TICK_COUNT_BITS-1:0] oh,
    input logic [lse_pkg::TICK_COUNT_BITS-1:0] ol
  );
    logic [lse_pkg::TICK_COUNT_BITS-1:0] t;
    if (bit_val) begin
      t = low ? ol : oh;
    end else begin
      t = low ? zl : zh;
    end
    // zero register means one tick
    return (t == '0) ? lse_pkg::TICK_COUNT_BITS'(1) : t;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_high_ticks <= lse_pkg::ZERO_HIGH_RESET;
      zero_low_ticks  <= lse_pkg::ZERO_LOW_RESET;
      one_high_ticks  <= lse_pkg::ONE_HIGH_RESET;
      one_low_ticks   <= lse_pkg::ONE_LOW_RESET;
    end else if (cfg_we) begin
      case (lse_pkg::cfg_reg_t'(cfg_index))
        lse_pkg::REG_ZERO_HIGH: zero_high_ticks <= cfg_data;
        lse_pkg::REG_ZERO_LOW:  zero_low_ticks  <= cfg_data;
        lse_pkg::REG_ONE_HIGH:  one_high_ticks  <= cfg_data;
        lse_pkg::REG_ONE_LOW:   one_low_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pop       = q_not_empty && (!out_valid || results.ready);
  assign ticks_dec = ticks_left - 1'b1;

  always_comb begin
    pixel_shift_next  = pixel_shift;
    bit_position_next = bit_position;
    in_low_phase_next = in_low_phase;
    ticks_left_next   = ticks_left;
    sending_next      = sending;
    refused_next      = 1'b0;
    if (q_data.is_load) begin
      if (sending) begin
        refused_next = 1'b1;
      end else begin
        pixel_shift_next  = q_data.pixel;
        bit_position_next = lse_pkg::PIXEL_TOP_BIT;
        in_low_phase_next = 1'b0;
        sending_next      = 1'b1;
        ticks_left_next   = phase_len(q_data.pixel[lse_pkg::PIXEL_BITS-1], 1'b0,
                                      zero_high_ticks, zero_low_ticks,
                                      one_high_ticks, one_low_ticks);
      end
    end else if (sending) begin
      ticks_left_next = ticks_dec;
      if (ticks_dec == '0) begin
        if (!in_low_phase) begin
          in_low_phase_next = 1'b1;
          ticks_left_next   = phase_len(pixel_shift[lse_pkg::PIXEL_BITS-1], 1'b1,
                                        zero_high_ticks, zero_low_ticks,
                                        one_high_ticks, one_low_ticks);
        end else if (bit_position == '0) begin
          in_low_phase_next = 1'b0;
          sending_next      = 1'b0;
        end else begin
          bit_position_next = bit_position - 1'b1;
          pixel_shift_next  = {pixel_shift[lse_pkg::PIXEL_BITS-2:0], 1'b0};
          in_low_phase_next = 1'b0;
          ticks_left_next   = phase_len(pixel_shift[lse_pkg::PIXEL_BITS-2], 1'b0,
                                        zero_high_ticks, zero_low_ticks,
                                        one_high_ticks, one_low_ticks);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_shift  <= '0;
      bit_position <= '0;
      in_low_phase <= 1'b0;
      ticks_left   <= '0;
      sending      <= 1'b0;
    end else if (pop) begin
      pixel_shift  <= pixel_shift_next;
      bit_position <= bit_position_next;
      in_low_phase <= in_low_phase_next;
      ticks_left   <= ticks_left_next;
      sending      <= sending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_line    <= sending_next && !in_low_phase_next;
      out_busy    <= sending_next;
      out_refused <= refused_next;
    end
  end

  assign results.valid      = out_valid;
  assign results.line_level = out_line;
  assign results.busy_res   = out_busy;
  assign results.refused    = out_refused;

  a_line_needs_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_line |-> out_busy)
    else $error("line high while not busy");

  a_refuse_needs_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_refused |-> out_busy)
    else $error("refused beat while idle");

  a_ticks_nonzero: assert property (@(posedge clk) disable iff (rst)
    sending |-> ticks_left != '0)
    else $error("phase counter empty while sending");

  a_bit_pos_range: assert property (@(posedge clk) disable iff (rst)
    sending |-> bit_position <= lse_pkg::PIXEL_TOP_BIT)
    else $error("bit position out of range");

  a_refuse_keeps_state: assert property (@(posedge clk) disable iff (rst)
    pop && q_data.is_load && sending |=> sending && $stable(pixel_shift))
    else $error("refused load disturbed the pixel");

endmodule

// ----- dv/rgb_led_serial_line_encoder_tb.sv -----
`timescale 1ns / 100ps

module rgb_led_serial_line_encoder_tb;
  import lse_pkg::*;

  localparam int CYCLE_LIMIT       = 400000;
  localparam int RESET_CYCLES      = 12;
  localparam int SETTLE_CYCLES     = 6;
  localparam int HOLD_CYCLES       = 300;
  localparam int REPORT_LIMIT      = 10;
  localparam int RANDOM_PER_PHASE  = 30;
  localparam int NUM_PHASES        = 6;
  localparam int RESET_PHASE_TICKS = 60;
  localparam int SPARE_INDEX_LO    = int'(REG_ONE_LOW) + 1;
  localparam int SPARE_INDEX_HI    = (1 << CFG_INDEX_BITS) - 1;

  localparam logic [TICK_COUNT_BITS-1:0] LONG_HIGH_TICKS = TICK_COUNT_BITS'(64);

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_LOAD = 1'b1;
  localparam logic TYPED     = 1'b1;
  localparam logic BY_MODEL  = 1'b0;

  typedef struct packed {
    logic                  kind;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } pixel_beat_t;

  typedef struct packed {
    logic line_level;
    logic busy;
    logic refused;
  } line_result_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0]      pixel;
    logic [BIT_POS_BITS-1:0]    bit_pos;
    logic                       low_phase;
    logic [TICK_COUNT_BITS-1:0] ticks_left;
    logic                       sending;
  } encoder_state_t;

  typedef struct packed {
    pixel_beat_t  beat;
    logic         typed;
    line_result_t want;
  } directed_row_t;

  localparam line_result_t RES_IDLE    = 3'b000;
  localparam line_result_t RES_LOADED  = 3'b110;
  localparam line_result_t RES_REFUSED = 3'b111;

  localparam int DIR_ROWS = 12;
  localparam directed_row_t DIRECTED [DIR_ROWS] = '{
    {KIND_TICK, 8'h00, 8'h00, 8'h00, TYPED,    RES_IDLE},
    {KIND_TICK, 8'hFF, 8'hFF, 8'hFF, TYPED,    RES_IDLE},
    {KIND_LOAD, 8'hFF, 8'hFF, 8'hFF, TYPED,    RES_LOADED},
    {KIND_LOAD, 8'h00, 8'h00, 8'h00, TYPED,    RES_REFUSED},
    {KIND_LOAD, 8'hA5, 8'h5A, 8'h3C, TYPED,    RES_REFUSED},
    {KIND_TICK, 8'h00, 8'h00, 8'h00, BY_MODEL, RES_IDLE},
    {KIND_TICK, 8'hFF, 8'h00, 8'hFF, BY_MODEL, RES_IDLE},
    {KIND_TICK, 8'h00, 8'hFF, 8'h00, BY_MODEL, RES_IDLE},
    {KIND_LOAD, 8'h80, 8'h01, 8'h7F, BY_MODEL, RES_IDLE},
    {KIND_TICK, 8'h12, 8'h34, 8'h56, BY_MODEL, RES_IDLE},
    {KIND_TICK, 8'h00, 8'h00, 8'h00, BY_MODEL, RES_IDLE},
    {KIND_LOAD, 8'h01, 8'h80, 8'hFE, BY_MODEL, RES_IDLE}
  };

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [CFG_INDEX_BITS-1:0]  cfg_index;
  logic [TICK_COUNT_BITS-1:0] cfg_data;

  lse_item_if   item_ch();
  lse_result_if result_ch();

  rgb_led_serial_line_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .items     (item_ch),
    .results   (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  logic [TICK_COUNT_BITS-1:0] tick_regs [0:3];
  encoder_state_t             line_state;
  line_result_t               expected_lines [$];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  bit hold_done;
  int hold_left;
  int cycle_count;
  int n_loads, n_refused, n_ticks, n_pixels, n_results, n_mismatch, n_settings;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [TICK_COUNT_BITS-1:0] tick_val(int unsigned n);
    return TICK_COUNT_BITS'(n);
  endfunction

  function automatic logic [TICK_COUNT_BITS-1:0] phase_ticks(logic bit_val, logic low);
    logic [TICK_COUNT_BITS-1:0] t;
    if (bit_val) t = low ? tick_regs[REG_ONE_LOW] : tick_regs[REG_ONE_HIGH];
    else t = low ? tick_regs[REG_ZERO_LOW] : tick_regs[REG_ZERO_HIGH];
    return (t == '0) ? TICK_COUNT_BITS'(1) : t;
  endfunction

  function automatic line_result_t encode_step(inout encoder_state_t st, input pixel_beat_t b);
    line_result_t r;
    r = '0;
    if (b.kind == KIND_LOAD) begin
      if (st.sending) begin
        r.refused = 1'b1;
      end else begin
        st.pixel      = {b.green, b.red, b.blue};
        st.bit_pos    = PIXEL_TOP_BIT;
        st.low_phase  = 1'b0;
        st.sending    = 1'b1;
        st.ticks_left = phase_ticks(st.pixel[st.bit_pos], 1'b0);
      end
    end else if (st.sending) begin
      st.ticks_left = st.ticks_left - 1'b1;
      if (st.ticks_left == '0) begin
        if (!st.low_phase) begin
          st.low_phase  = 1'b1;
          st.ticks_left = phase_ticks(st.pixel[st.bit_pos], 1'b1);
        end else if (st.bit_pos == '0) begin
          st.low_phase = 1'b0;
          st.sending   = 1'b0;
        end else begin
          st.bit_pos    = st.bit_pos - 1'b1;
          st.low_phase  = 1'b0;
          st.ticks_left = phase_ticks(st.pixel[st.bit_pos], 1'b0);
        end
      end
    end
    r.line_level = st.sending && !st.low_phase;
    r.busy       = st.sending;
    return r;
  endfunction

  function automatic void flag_mismatch(string what);
    n_mismatch++;
    if (n_mismatch <= REPORT_LIMIT) $display("%0t: %s", $time, what);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      hold_left       <= 0;
      hold_done       <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left       <= HOLD_CYCLES;
      hold_done       <= 1'b1;
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left       <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    line_result_t want;
    line_result_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      n_results++;
      got = {result_ch.line_level, result_ch.busy_res, result_ch.refused};
      if (expected_lines.size() == 0) begin
        flag_mismatch($sformatf("unexpected result beat: line_level=%0b busy=%0b refused=%0b",
                                got.line_level, got.busy, got.refused));
      end else begin
        want = expected_lines.pop_front();
        if (got.line_level !== want.line_level || got.busy !== want.busy ||
            got.refused !== want.refused) begin
          flag_mismatch($sformatf({"result %0d: expected line_level=%0b busy=%0b refused=%0b,",
                                   " got line_level=%0b busy=%0b refused=%0b"},
                                  n_results, want.line_level, want.busy, want.refused,
                                  got.line_level, got.busy, got.refused));
        end
      end
    end
  end

  task automatic push_beat(input pixel_beat_t b, input logic use_typed, input line_result_t typed);
    line_result_t r;
    logic         was_sending;
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.kind  <= b.kind;
    item_ch.red   <= b.red;
    item_ch.green <= b.green;
    item_ch.blue  <= b.blue;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    was_sending = line_state.sending;
    r = encode_step(line_state, b);
    expected_lines.push_back(use_typed ? typed : r);
    if (b.kind == KIND_LOAD) begin
      n_loads++;
      if (r.refused) n_refused++;
    end else begin
      n_ticks++;
    end
    if (was_sending && !line_state.sending) n_pixels++;
  endtask

  function automatic pixel_beat_t random_beat(int load_pct);
    pixel_beat_t b;
    b.kind  = ($urandom_range(99) < load_pct) ? KIND_LOAD : KIND_TICK;
    b.red   = COLOR_BITS'($urandom);
    b.green = COLOR_BITS'($urandom);
    b.blue  = COLOR_BITS'($urandom);
    return b;
  endfunction

  // tick out the current pixel, with the odd load that must be refused
  task automatic finish_pixel();
    while (line_state.sending) push_beat(random_beat(3), BY_MODEL, RES_IDLE);
  endtask

  task automatic run_random(int n_items);
    int          done;
    pixel_beat_t b;
    done = 0;
    while (done < n_items) begin
      b = random_beat(line_state.sending ? 8 : 85);
      if (b.kind == KIND_LOAD || line_state.sending) done++;
      push_beat(b, BY_MODEL, RES_IDLE);
    end
    finish_pixel();
  endtask

  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tick_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [TICK_COUNT_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx <= REG_ONE_LOW) tick_regs[idx] = val;
  endtask

  task automatic set_timing(input logic [TICK_COUNT_BITS-1:0] zero_hi, zero_lo, one_hi, one_lo,
                            input bit with_spare);
    wait_idle();
    write_tick_reg(REG_ZERO_HIGH, zero_hi);
    write_tick_reg(REG_ZERO_LOW, zero_lo);
    write_tick_reg(REG_ONE_HIGH, one_hi);
    write_tick_reg(REG_ONE_LOW, one_lo);
    // indexes past the register list must not disturb the timing
    if (with_spare) begin
      for (int i = SPARE_INDEX_LO; i <= SPARE_INDEX_HI; i++) begin
        write_tick_reg(CFG_INDEX_BITS'(i), '1);
      end
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin
    pixel_beat_t long_pixel;
    clk             = 1'b0;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    item_ch.valid   = 1'b0;
    item_ch.kind    = KIND_TICK;
    item_ch.red     = '0;
    item_ch.green   = '0;
    item_ch.blue    = '0;
    result_ch.ready = 1'b0;
    hold_req        = 1'b0;
    cycle_count     = 0;
    n_settings      = 1;
    line_state      = '0;
    tick_regs[REG_ZERO_HIGH] = ZERO_HIGH_RESET;
    tick_regs[REG_ZERO_LOW]  = ZERO_LOW_RESET;
    tick_regs[REG_ONE_HIGH]  = ONE_HIGH_RESET;
    tick_regs[REG_ONE_LOW]   = ONE_LOW_RESET;
    send_idle_pct = 38;
    recv_idle_pct = 59;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset timing: idle ticks, a load, refused loads, most of the first high phase
    for (int i = 0; i < DIR_ROWS; i++) begin
      push_beat(DIRECTED[i].beat, DIRECTED[i].typed, DIRECTED[i].want);
    end
    for (int i = 0; i < RESET_PHASE_TICKS; i++) begin
      push_beat(random_beat(0), BY_MODEL, RES_IDLE);
    end
    // high phase still runs on its reset count, the rest of the pixel is short
    set_timing(tick_val(1), tick_val(1), tick_val(1), tick_val(1), 1'b0);
    finish_pixel();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 38;
        recv_idle_pct = 59;
      end else if (ph < 4) begin
        send_idle_pct = 59;
        recv_idle_pct = 38;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        0: set_timing(tick_val(1), tick_val(1), tick_val(1), tick_val(1), 1'b0);
        1: set_timing('0, '0, '0, '0, 1'b1);
        2: set_timing(tick_val($urandom_range(3, 1)), tick_val($urandom_range(3, 1)),
                      tick_val($urandom_range(3, 1)), tick_val($urandom_range(3, 1)), 1'b0);
        3: set_timing(tick_val(3), tick_val(2), tick_val(1), tick_val(4), 1'b0);
        4: set_timing(tick_val($urandom_range(4, 1)), tick_val($urandom_range(4, 1)),
                      tick_val($urandom_range(4, 1)), tick_val($urandom_range(4, 1)), 1'b0);
        default: set_timing(tick_val(1), tick_val(1), LONG_HIGH_TICKS, tick_val(1), 1'b0);
      endcase
      if (ph == 4) hold_req <= 1'b1;
      if (ph == NUM_PHASES - 1) begin
        // one bit at a long high time, the rest at the shortest
        long_pixel = {KIND_LOAD, 8'h00, 8'h80, 8'h00};
        push_beat(long_pixel, BY_MODEL, RES_IDLE);
        finish_pixel();
      end else begin
        run_random(RANDOM_PER_PHASE);
      end
    end

    wait_idle();
    $display("Run covered %0d pixel loads (%0d refused), %0d ticks, %0d pixels sent",
             n_loads, n_refused, n_ticks, n_pixels);
    $display("under %0d timing settings; %0d result beats checked, %0d mismatches",
             n_settings, n_results, n_mismatch);
    if (n_mismatch == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
